FILE: rtl/core/kef_pkg.sv
// ----------------------------------------------------------------------------
// kef_pkg
// Shared types and constants for the key event queue: beat layouts, the
// stored entry format, operation codes and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kef_pkg;

  localparam int CNT_W = 5;

  localparam logic [1:0] OP_QUEUE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;

  localparam logic [1:0] KEY_PRESSED  = 2'd1;
  localparam logic [1:0] KEY_RELEASED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic             event_ok;
    logic             item_present;
    logic [1:0]       item_state;
    logic [7:0]       item_key;
    logic [CNT_W-1:0] depth;
    logic [31:0]      reads_total;
    logic [31:0]      empty_reads_total;
    logic [31:0]      dropped_total;
  } out_item_t;

  typedef struct packed {
    logic [1:0] state;
    logic [7:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH2,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/kef_ram.sv
// ----------------------------------------------------------------------------
// kef_ram
// Simple dual-port entry store: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kef_ram #(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire kef_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output kef_pkg::entry_t      rdata
);
  import kef_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/key_event_fifo_with_drop.sv
// ----------------------------------------------------------------------------
// key_event_fifo_with_drop
// Keyboard event queue with drop on full. Queue beats push a press and a
// release entry; read beats pop the head; peek beats report the head.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+-------------------------------
//   input    | start, busy, in_item       | taken when start && !busy
//   result   | out_valid, out_item        | one-cycle strobe, no backpressure
//
// Every beat passes through the accept cycle and then one more state:
// ST_PUSH2 for the release entry on the single write port, or ST_READ to
// wait for the entry store's registered read data. The result strobes in
// the cycle after that, while busy is already low so the next beat may enter.
// Synchronous reset clears pointers, counters and control; the entry store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_event_fifo_with_drop #(
  parameter int QUEUE_DEPTH = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output      logic         busy,
  input  wire kef_pkg::in_item_t in_item,
  output      logic         out_valid,
  output kef_pkg::out_item_t out_item
);
  import kef_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_EXT  = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0]    LAST_IDX   = AW'(QUEUE_DEPTH - 1);

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [7:0]       key_r, key_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      reads_r, reads_nxt;
  logic [31:0]      empty_r, empty_nxt;
  logic [31:0]      drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic             we;
  entry_t           wdata;
  entry_t           rdata;

  assign accept    = start && (state_r == ST_IDLE);
  assign tail_sum  = (CNT_W + 1)'(head_r) + {1'b0, count_r};
  assign tail_wrap = (tail_sum >= DEPTH_EXT) ? (tail_sum - DEPTH_EXT) : tail_sum;

  kef_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tail_wrap[AW-1:0]),
    .wdata (wdata),
    .re    (accept),
    .raddr (head_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      reads_r     <= '0;
      empty_r     <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      reads_r     <= reads_nxt;
      empty_r     <= empty_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    reads_nxt     = reads_r;
    empty_nxt     = empty_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    we            = 1'b0;
    wdata.state   = KEY_PRESSED;
    wdata.key     = key_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_item.op;
          key_nxt = in_item.key_code;
          if (in_item.op == OP_QUEUE) begin
            // push press entry
            wdata.key = in_item.key_code;
            if (count_r < DEPTH_C) begin
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
            end else if (drop_r != '1) begin
              drop_nxt = drop_r + 1'b1;
            end
            state_nxt = ST_PUSH2;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_PUSH2: begin
        // push release entry
        wdata.state = KEY_RELEASED;
        if (count_r < DEPTH_C) begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end else if (drop_r != '1) begin
          drop_nxt = drop_r + 1'b1;
        end
        out_item_nxt              = '0;
        out_item_nxt.depth        = count_nxt;
        out_item_nxt.reads_total  = reads_r;
        out_item_nxt.empty_reads_total = empty_r;
        out_item_nxt.dropped_total     = drop_nxt;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        out_item_nxt = '0;
        if (op_r == OP_READ) begin
          if (count_r == '0) begin
            empty_nxt = empty_r + 1'b1;
          end else begin
            // pop head
            out_item_nxt.item_present = 1'b1;
            out_item_nxt.item_state   = rdata.state;
            out_item_nxt.item_key     = rdata.key;
            out_item_nxt.event_ok     = (rdata.key != 8'd0);
            head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            reads_nxt = reads_r + 1'b1;
          end
        end else if (op_r == OP_PEEK) begin
          if (count_r != '0) begin
            out_item_nxt.item_present = 1'b1;
            out_item_nxt.item_state   = rdata.state;
            out_item_nxt.item_key     = rdata.key;
          end
        end
        out_item_nxt.depth             = count_nxt;
        out_item_nxt.reads_total       = reads_nxt;
        out_item_nxt.empty_reads_total = empty_nxt;
        out_item_nxt.dropped_total     = drop_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_IDX)
    else $error("head index out of range");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> drop_r >= $past(drop_r))
    else $error("drop counter decreased");

  a_write_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> count_r < DEPTH_C)
    else $error("write into full queue");

endmodule

`default_nettype wire
